// ===== rtl/x224_pkg.sv =====
// ----------------------------------------------------------------------------
// x224_pkg
// Shared types and constants for the X.224 TPDU header parser: TPDU codes,
// negotiation codes, the result record and the push bundle into the queue.
// ----------------------------------------------------------------------------
package x224_pkg;

  // frame byte counter saturates here
  localparam logic [15:0] MAX_FRAME_BYTES = 16'd65535;

  // TPDU codes and data-frame markers
  localparam logic [7:0] TPDU_CR     = 8'hE0;
  localparam logic [7:0] TPDU_CC     = 8'hD0;
  localparam logic [7:0] TPDU_DT     = 8'hF0;
  localparam logic [7:0] DT_LI_BYTE  = 8'h02;
  localparam logic [7:0] DT_EOT_BYTE = 8'h80;

  // negotiation block codes
  localparam logic [7:0]  NEG_TYPE_REQ  = 8'd1;
  localparam logic [7:0]  NEG_TYPE_RSP  = 8'd2;
  localparam logic [7:0]  NEG_TYPE_FAIL = 8'd3;
  localparam logic [15:0] NEG_BLOCK_LEN = 16'd8;

  // header geometry
  localparam logic [15:0] HDR_MIN_BYTES  = 16'd7;
  localparam logic [15:0] NEG_MIN_FRAME  = 16'd15;
  localparam logic [7:0]  CR_NEG_MIN_LI  = 8'd14;
  localparam logic [7:0]  CC_NEG_START   = 8'd7;
  localparam logic [7:0]  HDR_MIN_LI     = 8'd6;
  localparam logic [15:0] DT_HDR_BYTES   = 16'd3;

  // configuration port
  localparam int unsigned PADDR_W          = 3;
  localparam logic [2:0]  ACCEPT_MASK_RST  = 3'd7;
  localparam logic        REG_ACCEPT_MASK  = 1'b0;  // word index of accept_mask

  // result queue
  localparam int unsigned OUTQ_DEPTH = 8;
  localparam int unsigned OUTQ_AW    = 3;

  typedef enum logic [1:0] {
    KIND_CR      = 2'd0,
    KIND_CC      = 2'd1,
    KIND_DT      = 2'd2,
    KIND_UNKNOWN = 2'd3
  } kind_t;

  typedef enum logic {
    REC_DATA    = 1'b0,
    REC_SUMMARY = 1'b1
  } rec_kind_t;

  typedef struct packed {
    rec_kind_t   record_kind;
    kind_t       frame_kind;
    logic        parse_error;
    logic [15:0] dest_ref;
    logic [15:0] src_ref;
    logic [7:0]  class_opt;
    logic        neg_present;
    logic [1:0]  neg_code;
    logic [7:0]  neg_flags;
    logic [31:0] neg_value;
    logic [15:0] body_len;
    logic [7:0]  payload_byte;
  } rec_t;

  // zero, one or two records written into the queue in one cycle
  typedef struct packed {
    logic [1:0] count;
    rec_t       first;
    rec_t       second;
  } push_t;

endpackage

// ===== rtl/x224_if.sv =====
// ----------------------------------------------------------------------------
// x224 channel interfaces
// Byte input channel and record output channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface x224_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       end_of_frame;

  modport source (output valid, frame_byte, end_of_frame, input ready);
  modport sink   (input valid, frame_byte, end_of_frame, output ready);
endinterface

interface x224_out_if;
  logic        valid;
  logic        ready;
  logic        record_kind;
  logic [1:0]  frame_kind;
  logic        parse_error;
  logic [15:0] dest_ref;
  logic [15:0] src_ref;
  logic [7:0]  class_opt;
  logic        neg_present;
  logic [1:0]  neg_code;
  logic [7:0]  neg_flags;
  logic [31:0] neg_value;
  logic [15:0] body_len;
  logic [7:0]  payload_byte;

  modport source (
    output valid, record_kind, frame_kind, parse_error, dest_ref, src_ref,
           class_opt, neg_present, neg_code, neg_flags, neg_value, body_len,
           payload_byte,
    input  ready
  );
  modport sink (
    input  valid, record_kind, frame_kind, parse_error, dest_ref, src_ref,
           class_opt, neg_present, neg_code, neg_flags, neg_value, body_len,
           payload_byte,
    output ready
  );
endinterface

// ===== rtl/x224_cfg.sv =====
// ----------------------------------------------------------------------------
// x224_cfg
// APB register slave holding the frame-kind accept mask.
// ----------------------------------------------------------------------------
module x224_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [x224_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output logic [2:0]                     accept_mask
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready
                  && (paddr[x224_pkg::PADDR_W-1] == x224_pkg::REG_ACCEPT_MASK);

  always_ff @(posedge clk) begin
    if (rst) begin
      accept_mask <= x224_pkg::ACCEPT_MASK_RST;
    end else if (wr_en) begin
      accept_mask <= pwdata[2:0];
    end
  end

  always_comb begin
    if (paddr[x224_pkg::PADDR_W-1] == x224_pkg::REG_ACCEPT_MASK) begin
      prdata = {29'd0, accept_mask};
    end else begin
      prdata = 32'd0;
    end
  end

endmodule

// ===== rtl/x224_parse.sv =====
// ----------------------------------------------------------------------------
// x224_parse
// Input register and per-byte header parser: tracks position in the frame,
// captures header and negotiation fields, forms data and summary records.
// ----------------------------------------------------------------------------
module x224_parse (
  input  logic                clk,
  input  logic                rst,
  x224_in_if.sink             byte_in,
  input  logic                room,
  input  logic [2:0]          accept_mask,
  output logic                pending,
  output x224_pkg::push_t     push
);

  logic        pipe_valid;
  logic [7:0]  byte_q;
  logic        eof_q;

  logic [15:0]       byte_position, byte_position_next;
  logic [7:0]        length_indicator, length_indicator_next;
  logic              first_bytes_ok, first_bytes_ok_next;
  x224_pkg::kind_t   kind_seen, kind_seen_next;
  logic [15:0]       dest_ref_reg, dest_ref_reg_next;
  logic [15:0]       src_ref_reg, src_ref_reg_next;
  logic [7:0]        class_reg, class_reg_next;
  logic [7:0]        neg_type_reg, neg_type_reg_next;
  logic [7:0]        neg_flags_reg, neg_flags_reg_next;
  logic [15:0]       neg_length_reg, neg_length_reg_next;
  logic [31:0]       neg_value_reg, neg_value_reg_next;

  logic        accept;
  logic [15:0] cnt;
  logic        neg_has;
  logic [7:0]  neg_start;
  logic [15:0] neg_off;
  logic        neg_win;
  logic [2:0]  neg_idx;
  logic        data_fwd;
  logic        kind_err;
  logic        err;
  logic        present;
  logic [15:0] body;
  logic [15:0] li_plus1;
  x224_pkg::rec_t data_rec;
  x224_pkg::rec_t sum_rec;

  assign byte_in.ready = room;
  assign accept        = byte_in.valid && room;
  assign pending       = pipe_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_valid <= 1'b0;
    end else begin
      pipe_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_q <= byte_in.frame_byte;
      eof_q  <= byte_in.end_of_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= 16'd0;
    end else if (pipe_valid) begin
      byte_position <= byte_position_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_valid) begin
      length_indicator <= length_indicator_next;
      first_bytes_ok   <= first_bytes_ok_next;
      kind_seen        <= kind_seen_next;
      dest_ref_reg     <= dest_ref_reg_next;
      src_ref_reg      <= src_ref_reg_next;
      class_reg        <= class_reg_next;
      neg_type_reg     <= neg_type_reg_next;
      neg_flags_reg    <= neg_flags_reg_next;
      neg_length_reg   <= neg_length_reg_next;
      neg_value_reg    <= neg_value_reg_next;
    end
  end

  // negotiation block window for the current byte
  always_comb begin
    neg_has   = 1'b0;
    neg_start = 8'd0;
    if (kind_seen == x224_pkg::KIND_CR && length_indicator >= x224_pkg::CR_NEG_MIN_LI) begin
      neg_has   = 1'b1;
      neg_start = length_indicator - 8'd7;
    end else if (kind_seen == x224_pkg::KIND_CC) begin
      neg_has   = 1'b1;
      neg_start = x224_pkg::CC_NEG_START;
    end
    neg_off = byte_position - {8'd0, neg_start};
    neg_win = neg_has && (byte_position >= {8'd0, neg_start}) && (neg_off < 16'd8);
    neg_idx = neg_off[2:0];
  end

  assign cnt = (byte_position == x224_pkg::MAX_FRAME_BYTES) ? x224_pkg::MAX_FRAME_BYTES
                                                            : byte_position + 16'd1;

  // field capture
  always_comb begin
    length_indicator_next = length_indicator;
    first_bytes_ok_next   = first_bytes_ok;
    kind_seen_next        = kind_seen;
    dest_ref_reg_next     = dest_ref_reg;
    src_ref_reg_next      = src_ref_reg;
    class_reg_next        = class_reg;
    neg_type_reg_next     = neg_type_reg;
    neg_flags_reg_next    = neg_flags_reg;
    neg_length_reg_next   = neg_length_reg;
    neg_value_reg_next    = neg_value_reg;

    if (byte_position == 16'd0) begin
      length_indicator_next = byte_q;
      first_bytes_ok_next   = (byte_q == x224_pkg::DT_LI_BYTE);
      kind_seen_next        = x224_pkg::KIND_UNKNOWN;
      dest_ref_reg_next     = 16'd0;
      src_ref_reg_next      = 16'd0;
      class_reg_next        = 8'd0;
      neg_type_reg_next     = 8'd0;
      neg_flags_reg_next    = 8'd0;
      neg_length_reg_next   = 16'd0;
      neg_value_reg_next    = 32'd0;
    end else if (byte_position == 16'd1) begin
      priority if (byte_q == x224_pkg::TPDU_CR) begin
        kind_seen_next = x224_pkg::KIND_CR;
      end else if (byte_q == x224_pkg::TPDU_CC) begin
        kind_seen_next = x224_pkg::KIND_CC;
      end else if (byte_q == x224_pkg::TPDU_DT) begin
        kind_seen_next = x224_pkg::KIND_DT;
      end else begin
        kind_seen_next = x224_pkg::KIND_UNKNOWN;
      end
    end else if (byte_position != x224_pkg::MAX_FRAME_BYTES) begin
      if (byte_position == 16'd2 && byte_q != x224_pkg::DT_EOT_BYTE) begin
        first_bytes_ok_next = 1'b0;
      end
      if (byte_position == 16'd2 || byte_position == 16'd3) begin
        dest_ref_reg_next = {dest_ref_reg[7:0], byte_q};
      end else if (byte_position == 16'd4 || byte_position == 16'd5) begin
        src_ref_reg_next = {src_ref_reg[7:0], byte_q};
      end else if (byte_position == 16'd6) begin
        class_reg_next = byte_q;
      end
      if (neg_win) begin
        unique case (neg_idx)
          3'd0:    neg_type_reg_next = byte_q;
          3'd1:    neg_flags_reg_next = byte_q;
          3'd2:    neg_length_reg_next[7:0] = byte_q;
          3'd3:    neg_length_reg_next[15:8] = byte_q;
          default: neg_value_reg_next[{neg_idx[1:0], 3'b000} +: 8] = byte_q;
        endcase
      end
    end

    byte_position_next = eof_q ? 16'd0 : cnt;
  end

  // summary checks, on the updated frame state
  always_comb begin
    unique case (kind_seen_next)
      x224_pkg::KIND_CR: kind_err = !accept_mask[0];
      x224_pkg::KIND_CC: kind_err = !accept_mask[1];
      x224_pkg::KIND_DT: kind_err = !accept_mask[2];
      default:           kind_err = 1'b1;
    endcase

    li_plus1 = {8'd0, length_indicator_next} + 16'd1;
    err      = kind_err;
    present  = 1'b0;
    body     = 16'd0;

    if (!err && kind_seen_next != x224_pkg::KIND_DT) begin
      if (cnt < x224_pkg::HDR_MIN_BYTES || length_indicator_next < x224_pkg::HDR_MIN_LI
          || li_plus1 > cnt) begin
        err = 1'b1;
      end
    end

    if (!err) begin
      unique case (kind_seen_next)
        x224_pkg::KIND_CR: begin
          if (li_plus1 >= x224_pkg::NEG_MIN_FRAME
              && neg_type_reg_next == x224_pkg::NEG_TYPE_REQ) begin
            if (neg_length_reg_next != x224_pkg::NEG_BLOCK_LEN) begin
              err = 1'b1;
            end else begin
              present = 1'b1;
            end
          end
          body = li_plus1 - x224_pkg::HDR_MIN_BYTES - (present ? 16'd8 : 16'd0);
        end
        x224_pkg::KIND_CC: begin
          if (cnt >= x224_pkg::NEG_MIN_FRAME) begin
            if ((neg_type_reg_next != x224_pkg::NEG_TYPE_RSP
                 && neg_type_reg_next != x224_pkg::NEG_TYPE_FAIL)
                || neg_length_reg_next != x224_pkg::NEG_BLOCK_LEN) begin
              err = 1'b1;
            end else begin
              present = 1'b1;
            end
          end
        end
        x224_pkg::KIND_DT: begin
          if (cnt < x224_pkg::DT_HDR_BYTES || !first_bytes_ok_next) begin
            err = 1'b1;
          end else begin
            body = cnt - x224_pkg::DT_HDR_BYTES;
          end
        end
        default: begin
          err = 1'b1;
        end
      endcase
    end
  end

  // record assembly
  always_comb begin
    data_rec              = '0;
    data_rec.record_kind  = x224_pkg::REC_DATA;
    data_rec.frame_kind   = x224_pkg::KIND_DT;
    data_rec.payload_byte = byte_q;

    sum_rec             = '0;
    sum_rec.record_kind = x224_pkg::REC_SUMMARY;
    sum_rec.frame_kind  = kind_seen_next;
    sum_rec.parse_error = err;
    if (!err) begin
      if (kind_seen_next != x224_pkg::KIND_DT) begin
        sum_rec.dest_ref  = dest_ref_reg_next;
        sum_rec.src_ref   = src_ref_reg_next;
        sum_rec.class_opt = class_reg_next;
      end
      if (present) begin
        sum_rec.neg_present = 1'b1;
        sum_rec.neg_code    = neg_type_reg_next[1:0];
        sum_rec.neg_flags   = neg_flags_reg_next;
        sum_rec.neg_value   = neg_value_reg_next;
      end
      sum_rec.body_len = body;
    end
  end

  // payload byte of an accepted, well-formed data frame
  assign data_fwd = (byte_position >= 16'd3) && (kind_seen == x224_pkg::KIND_DT)
                    && first_bytes_ok && accept_mask[2];

  always_comb begin
    push = '0;
    if (pipe_valid) begin
      if (data_fwd) begin
        push.first  = data_rec;
        push.second = sum_rec;
        push.count  = eof_q ? 2'd2 : 2'd1;
      end else begin
        push.first = sum_rec;
        push.count = eof_q ? 2'd1 : 2'd0;
      end
    end
  end

endmodule

// ===== rtl/x224_outq.sv =====
// ----------------------------------------------------------------------------
// x224_outq
// Eight-entry result queue taking up to two records a cycle; it also grants
// input room so that a byte still in the parse register always fits.
// ----------------------------------------------------------------------------
module x224_outq (
  input  logic                clk,
  input  logic                rst,
  input  x224_pkg::push_t     push,
  input  logic                pending,
  output logic                room,
  x224_out_if.source          rec_out
);

  x224_pkg::rec_t                  mem [x224_pkg::OUTQ_DEPTH];
  logic [x224_pkg::OUTQ_AW-1:0]    wr_ptr, rd_ptr;
  logic [x224_pkg::OUTQ_AW:0]      count, count_next;
  logic                            pop;
  logic [x224_pkg::OUTQ_AW-1:0]    wr_ptr_b;
  x224_pkg::rec_t                  head;

  assign pop      = rec_out.valid && rec_out.ready;
  assign wr_ptr_b = wr_ptr + x224_pkg::OUTQ_AW'(1);

  // room for the byte in the parse register and the new one, two records each
  assign room = ({1'b0, count} + {3'd0, pending, 1'b0})
                <= (x224_pkg::OUTQ_AW + 2)'(x224_pkg::OUTQ_DEPTH - 2);

  assign count_next = count + (x224_pkg::OUTQ_AW + 1)'(push.count)
                      - (x224_pkg::OUTQ_AW + 1)'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + x224_pkg::OUTQ_AW'(push.count);
      rd_ptr <= rd_ptr + x224_pkg::OUTQ_AW'(pop);
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr_b] <= push.second;
    end
  end

  assign head                 = mem[rd_ptr];
  assign rec_out.valid        = (count != '0);
  assign rec_out.record_kind  = head.record_kind;
  assign rec_out.frame_kind   = head.frame_kind;
  assign rec_out.parse_error  = head.parse_error;
  assign rec_out.dest_ref     = head.dest_ref;
  assign rec_out.src_ref      = head.src_ref;
  assign rec_out.class_opt    = head.class_opt;
  assign rec_out.neg_present  = head.neg_present;
  assign rec_out.neg_code     = head.neg_code;
  assign rec_out.neg_flags    = head.neg_flags;
  assign rec_out.neg_value    = head.neg_value;
  assign rec_out.body_len     = head.body_len;
  assign rec_out.payload_byte = head.payload_byte;

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count_next <= (x224_pkg::OUTQ_AW + 1)'(x224_pkg::OUTQ_DEPTH))
    else $error("result queue overflow");

  a_ptr_count: assert property (@(posedge clk) disable iff (rst)
    (wr_ptr - rd_ptr) == count[x224_pkg::OUTQ_AW-1:0])
    else $error("queue pointers disagree with fill count");

  a_push_code: assert property (@(posedge clk) disable iff (rst)
    push.count != 2'd3)
    else $error("more than two records pushed");

  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    push.count == 2'd2 |-> push.first.record_kind == x224_pkg::REC_DATA
                           && push.second.record_kind == x224_pkg::REC_SUMMARY)
    else $error("record pair out of order");

  a_room_pending: assert property (@(posedge clk) disable iff (rst)
    room |=> count <= (x224_pkg::OUTQ_AW + 1)'(x224_pkg::OUTQ_DEPTH - 2))
    else $error("room granted without space for queued bytes");

endmodule

// ===== rtl/x224_tpdu_parser.sv =====
// ----------------------------------------------------------------------------
// x224_tpdu_parser
// X.224 TPDU header parser with negotiation block extraction.
// ----------------------------------------------------------------------------
// byte_in carries the bytes of one TPKT payload, one per beat, with
// end_of_frame on the last one. rec_out carries records: one beat for each
// forwarded data payload byte, and a summary beat closing every frame with the
// kind, error flag, references, class option, negotiation block and length.
// A byte is registered when it is taken and parsed in the next cycle; its
// records are written to an eight-entry queue at the end of that cycle. A new
// byte is taken every cycle, with at most one record per byte out; a data
// frame ending emits two records for its last byte, which the queue absorbs.
// When rec_out stalls, byte_in.ready drops once the queue cannot hold two
// records each for the byte in flight and one more.
// Reset clears the frame position, the queue and sets the accept mask to all
// kinds. The accept mask sits at APB word 0 (paddr 0); write it only while the
// block is idle.
// ----------------------------------------------------------------------------
module x224_tpdu_parser (
  input  logic                          clk,
  input  logic                          rst,
  x224_in_if.sink                       byte_in,
  x224_out_if.source                    rec_out,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [x224_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  logic             room;
  logic             pending;
  logic [2:0]       accept_mask;
  x224_pkg::push_t  push;

  x224_cfg u_cfg (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .accept_mask (accept_mask)
  );

  x224_parse u_parse (
    .clk         (clk),
    .rst         (rst),
    .byte_in     (byte_in),
    .room        (room),
    .accept_mask (accept_mask),
    .pending     (pending),
    .push        (push)
  );

  x224_outq u_outq (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .pending (pending),
    .room    (room),
    .rec_out (rec_out)
  );

endmodule

// ===== verif/x224_tpdu_parser_tb.sv =====
// ----------------------------------------------------------------------------
// x224_tpdu_parser_tb
// Feeds TPKT payload bytes into the parser and checks every record it emits.
// A byte-level model of the parser runs on each accepted beat and queues the
// records it expects. The stream is directed corner frames first, then random
// requests, confirms, data frames and noise under changing accept masks and
// idle patterns.
// ----------------------------------------------------------------------------
module x224_tpdu_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT     = 1000000;
  localparam int unsigned SEG_BYTES       = 110;
  localparam int unsigned NEG_BLOCK_BYTES = 8;
  localparam int unsigned DRAIN_CYCLES    = 8;
  localparam logic [x224_pkg::PADDR_W-1:0] ADDR_ACCEPT_MASK =
    x224_pkg::PADDR_W'(4 * int'(x224_pkg::REG_ACCEPT_MASK));
  localparam logic [2:0] MASK_PLAN [9] = '{3'd7, 3'd0, 3'd1, 3'd2, 3'd4, 3'd3, 3'd5,
                                           3'd6, 3'd7};

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                         psel    = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite  = 1'b0;
  logic [x224_pkg::PADDR_W-1:0] paddr   = '0;
  logic [31:0]                  pwdata  = '0;
  logic [31:0]                  prdata;
  logic                         pready;

  x224_in_if  byte_if ();
  x224_out_if rec_if ();

  x224_tpdu_parser uut (
    .clk     (clk),
    .rst     (rst),
    .byte_in (byte_if),
    .rec_out (rec_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  beat_t           pending_beats [$];
  x224_pkg::rec_t  expected_recs [$];
  int unsigned error_count  = 0;
  int unsigned cycle_count  = 0;
  int unsigned queued_count = 0;
  int unsigned src_idle_pct = 0;
  int unsigned snk_idle_pct = 0;

  // parser model state
  logic [2:0]      accept_mask_q = x224_pkg::ACCEPT_MASK_RST;
  int unsigned     frame_pos     = 0;
  logic [7:0]      hdr_li        = '0;
  logic            dt_marks_ok   = 1'b0;
  x224_pkg::kind_t hdr_kind      = x224_pkg::KIND_CR;
  logic [15:0]     hdr_dst       = '0;
  logic [15:0]     hdr_src       = '0;
  logic [7:0]      hdr_class     = '0;
  logic [7:0]      neg_type_b    = '0;
  logic [7:0]      neg_flags_b   = '0;
  logic [15:0]     neg_len_w     = '0;
  logic [31:0]     neg_val_w     = '0;

  function automatic string rec_str(x224_pkg::rec_t r);
    return $sformatf({"rk=%0d fk=%0d err=%0d dst=%h src=%h cls=%h np=%0d nt=%0d nf=%h ",
                      "nv=%h len=%0d pb=%h"}, r.record_kind, r.frame_kind, r.parse_error,
                     r.dest_ref, r.src_ref, r.class_opt, r.neg_present, r.neg_code,
                     r.neg_flags, r.neg_value, r.body_len, r.payload_byte);
  endfunction

  function automatic void report_mismatch(string msg);
    error_count++;
    if (error_count <= 10)
      $display("%0t: %s", $realtime, msg);
  endfunction

  // advance the frame model by one byte and queue the records it causes
  task automatic parse_tpdu_byte(input logic [7:0] b, input logic eof);
    int unsigned    pos, cnt, start, idx, body;
    bit             has_blk, err, present;
    x224_pkg::rec_t r;
    pos = frame_pos;
    if (pos == 0) begin
      hdr_li      = b;
      dt_marks_ok = (b == x224_pkg::DT_LI_BYTE);
      hdr_kind    = x224_pkg::KIND_UNKNOWN;
      hdr_dst     = '0;
      hdr_src     = '0;
      hdr_class   = '0;
      neg_type_b  = '0;
      neg_flags_b = '0;
      neg_len_w   = '0;
      neg_val_w   = '0;
    end else if (pos == 1) begin
      hdr_kind = (b == x224_pkg::TPDU_CR) ? x224_pkg::KIND_CR :
                 (b == x224_pkg::TPDU_CC) ? x224_pkg::KIND_CC :
                 (b == x224_pkg::TPDU_DT) ? x224_pkg::KIND_DT : x224_pkg::KIND_UNKNOWN;
    end else if (pos < x224_pkg::MAX_FRAME_BYTES) begin
      if (pos == 2 && b != x224_pkg::DT_EOT_BYTE)
        dt_marks_ok = 1'b0;
      if (pos == 2 || pos == 3)
        hdr_dst = {hdr_dst[7:0], b};
      else if (pos == 4 || pos == 5)
        hdr_src = {hdr_src[7:0], b};
      else if (pos == 6)
        hdr_class = b;
      has_blk = 1'b0;
      start   = 0;
      if (hdr_kind == x224_pkg::KIND_CR && hdr_li >= x224_pkg::CR_NEG_MIN_LI) begin
        // request block is the last eight bytes of the li range
        start   = int'(hdr_li) + 1 - NEG_BLOCK_BYTES;
        has_blk = 1'b1;
      end else if (hdr_kind == x224_pkg::KIND_CC) begin
        start   = x224_pkg::CC_NEG_START;
        has_blk = 1'b1;
      end
      if (has_blk && pos >= start && pos < start + NEG_BLOCK_BYTES) begin
        idx = pos - start;
        case (idx)
          0: neg_type_b = b;
          1: neg_flags_b = b;
          2: neg_len_w[7:0] = b;
          3: neg_len_w[15:8] = b;
          default: neg_val_w[8 * (idx - 4) +: 8] = b;
        endcase
      end
    end

    if (pos >= x224_pkg::DT_HDR_BYTES && hdr_kind == x224_pkg::KIND_DT && dt_marks_ok
        && accept_mask_q[x224_pkg::KIND_DT]) begin
      r              = '0;
      r.record_kind  = x224_pkg::REC_DATA;
      r.frame_kind   = x224_pkg::KIND_DT;
      r.payload_byte = b;
      expected_recs.push_back(r);
    end

    cnt = (pos + 1 < x224_pkg::MAX_FRAME_BYTES) ? pos + 1 : x224_pkg::MAX_FRAME_BYTES;

    if (eof) begin
      err     = (hdr_kind == x224_pkg::KIND_UNKNOWN) ? 1'b1 : !accept_mask_q[hdr_kind];
      present = 1'b0;
      body    = 0;
      if (!err && hdr_kind != x224_pkg::KIND_DT) begin
        if (cnt < x224_pkg::HDR_MIN_BYTES || hdr_li < x224_pkg::HDR_MIN_LI
            || int'(hdr_li) + 1 > cnt)
          err = 1'b1;
      end
      if (!err && hdr_kind == x224_pkg::KIND_CR) begin
        // a block typed other than request is just cookie bytes
        if (int'(hdr_li) + 1 >= x224_pkg::NEG_MIN_FRAME
            && neg_type_b == x224_pkg::NEG_TYPE_REQ) begin
          if (neg_len_w != x224_pkg::NEG_BLOCK_LEN)
            err = 1'b1;
          else
            present = 1'b1;
        end
        body = int'(hdr_li) + 1 - x224_pkg::HDR_MIN_BYTES
               - (present ? NEG_BLOCK_BYTES : 0);
      end else if (!err && hdr_kind == x224_pkg::KIND_CC) begin
        if (cnt >= x224_pkg::NEG_MIN_FRAME) begin
          if ((neg_type_b != x224_pkg::NEG_TYPE_RSP && neg_type_b != x224_pkg::NEG_TYPE_FAIL)
              || neg_len_w != x224_pkg::NEG_BLOCK_LEN)
            err = 1'b1;
          else
            present = 1'b1;
        end
      end else if (!err && hdr_kind == x224_pkg::KIND_DT) begin
        if (cnt < x224_pkg::DT_HDR_BYTES || !dt_marks_ok)
          err = 1'b1;
        else
          body = cnt - x224_pkg::DT_HDR_BYTES;
      end

      r             = '0;
      r.record_kind = x224_pkg::REC_SUMMARY;
      r.frame_kind  = hdr_kind;
      r.parse_error = err;
      if (!err) begin
        if (hdr_kind != x224_pkg::KIND_DT) begin
          r.dest_ref  = hdr_dst;
          r.src_ref   = hdr_src;
          r.class_opt = hdr_class;
        end
        if (present) begin
          r.neg_present = 1'b1;
          r.neg_code    = neg_type_b[1:0];
          r.neg_flags   = neg_flags_b;
          r.neg_value   = neg_val_w;
        end
        r.body_len = body[15:0];
      end
      expected_recs.push_back(r);
      frame_pos = 0;
    end else begin
      frame_pos = cnt;
    end
  endtask

  // byte source
  always @(posedge clk) begin : byte_driver
    beat_t nxt;
    if (rst) begin
      byte_if.valid <= 1'b0;
    end else begin
      if (byte_if.valid && byte_if.ready)
        parse_tpdu_byte(byte_if.frame_byte, byte_if.end_of_frame);
      if (!byte_if.valid || byte_if.ready) begin
        if (pending_beats.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          nxt = pending_beats.pop_front();
          byte_if.valid        <= 1'b1;
          byte_if.frame_byte   <= nxt.data;
          byte_if.end_of_frame <= nxt.last;
        end else begin
          byte_if.valid <= 1'b0;
        end
      end
    end
  end

  // record sink and checker
  always @(posedge clk) begin : rec_monitor
    x224_pkg::rec_t got, want;
    if (rst) begin
      rec_if.ready <= 1'b0;
    end else begin
      if (rec_if.valid && rec_if.ready) begin
        got.record_kind  = x224_pkg::rec_kind_t'(rec_if.record_kind);
        got.frame_kind   = x224_pkg::kind_t'(rec_if.frame_kind);
        got.parse_error  = rec_if.parse_error;
        got.dest_ref     = rec_if.dest_ref;
        got.src_ref      = rec_if.src_ref;
        got.class_opt    = rec_if.class_opt;
        got.neg_present  = rec_if.neg_present;
        got.neg_code     = rec_if.neg_code;
        got.neg_flags    = rec_if.neg_flags;
        got.neg_value    = rec_if.neg_value;
        got.body_len     = rec_if.body_len;
        got.payload_byte = rec_if.payload_byte;
        if (expected_recs.size() == 0) begin
          report_mismatch({"unexpected record: ", rec_str(got)});
        end else begin
          want = expected_recs.pop_front();
          if (got !== want)
            report_mismatch({"record mismatch\n  exp ", rec_str(want), "\n  got ",
                             rec_str(got)});
        end
      end
      rec_if.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d records outstanding", cycle_count,
               expected_recs.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic void queue_bytes(input logic [7:0] fb[$]);
    beat_t bt;
    foreach (fb[i]) begin
      bt.data = fb[i];
      bt.last = (i == fb.size() - 1);
      pending_beats.push_back(bt);
    end
    queued_count += fb.size();
  endfunction

  function automatic void put_neg_block(ref logic [7:0] fb[$], input int at,
                                        input logic [7:0] ok_type);
    logic [31:0] val;
    int          k;
    case ($urandom_range(3))
      0: val = '0;
      1: val = '1;
      default: val = $urandom;
    endcase
    fb[at]     = ($urandom_range(5) == 0) ? 8'($urandom_range(4)) : ok_type;
    fb[at + 1] = 8'($urandom);
    if ($urandom_range(7) == 0) begin
      fb[at + 2] = 8'($urandom);
      fb[at + 3] = 8'($urandom);
    end else begin
      fb[at + 2] = x224_pkg::NEG_BLOCK_LEN[7:0];
      fb[at + 3] = x224_pkg::NEG_BLOCK_LEN[15:8];
    end
    for (k = 0; k < 4; k++)
      fb[at + 4 + k] = val[8 * k +: 8];
  endfunction

  function automatic void build_dt(ref logic [7:0] fb[$], input int pay_bytes);
    fb = '{x224_pkg::DT_LI_BYTE, x224_pkg::TPDU_DT, x224_pkg::DT_EOT_BYTE};
    repeat (pay_bytes) fb.push_back(8'($urandom));
  endfunction

  task automatic queue_random_frame();
    logic [7:0] fb[$];
    int         sel, li, n, i;
    sel = $urandom_range(99);
    if (sel < 30) begin
      li = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(6, 24);
      fb = '{8'(li), x224_pkg::TPDU_CR};
      for (i = 2; i <= ((li > 6) ? li : 6); i++)
        fb.push_back(8'($urandom));
      if (li >= x224_pkg::CR_NEG_MIN_LI && $urandom_range(4) != 0)
        put_neg_block(fb, li + 1 - NEG_BLOCK_BYTES, x224_pkg::NEG_TYPE_REQ);
      if ($urandom_range(5) == 0)
        repeat ($urandom_range(1, 3)) fb.push_back(8'($urandom));
    end else if (sel < 55) begin
      n  = $urandom_range(7, 20);
      li = ($urandom_range(7) == 0) ? $urandom_range(255) : $urandom_range(6, n - 1);
      fb = '{8'(li), x224_pkg::TPDU_CC};
      for (i = 2; i < n; i++)
        fb.push_back(8'($urandom));
      if (n >= x224_pkg::NEG_MIN_FRAME)
        put_neg_block(fb, x224_pkg::CC_NEG_START,
                      $urandom_range(1) ? x224_pkg::NEG_TYPE_RSP : x224_pkg::NEG_TYPE_FAIL);
    end else if (sel < 85) begin
      build_dt(fb, $urandom_range(10));
      // broken marker or kind byte
      if ($urandom_range(5) == 0)
        fb[$urandom_range(2)] = 8'($urandom);
    end else begin
      fb = {};
      repeat ($urandom_range(1, 12)) fb.push_back(8'($urandom));
    end
    if ($urandom_range(9) == 0)
      fb = fb[0 : $urandom_range(fb.size() - 1)];
    queue_bytes(fb);
  endtask

  task automatic wait_drained();
    while (pending_beats.size() != 0 || byte_if.valid || expected_recs.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic program_accept_mask(input logic [2:0] mask);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_ACCEPT_MASK;
    pwdata  <= {29'd0, mask};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    accept_mask_q = mask;
    // read it back
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[2:0] !== mask)
      report_mismatch($sformatf("accept_mask readback exp %0d got %0d", mask, prdata[2:0]));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    int          seg;
    int unsigned seg_start;
    byte_if.valid        = 1'b0;
    byte_if.frame_byte   = '0;
    byte_if.end_of_frame = 1'b0;
    rec_if.ready         = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    src_idle_pct = 20;
    snk_idle_pct = 86;
    // one-byte frame, minimal data frame with extreme payload, request with a
    // full negotiation block at the extremes, data frame with a bad marker
    queue_bytes('{8'hff});
    queue_bytes('{x224_pkg::DT_LI_BYTE, x224_pkg::TPDU_DT, x224_pkg::DT_EOT_BYTE,
                  8'h00, 8'hff});
    queue_bytes('{x224_pkg::CR_NEG_MIN_LI, x224_pkg::TPDU_CR, 8'h00, 8'h00, 8'hff, 8'hff,
                  8'h00, x224_pkg::NEG_TYPE_REQ, 8'hff, x224_pkg::NEG_BLOCK_LEN[7:0],
                  x224_pkg::NEG_BLOCK_LEN[15:8], 8'hff, 8'hff, 8'hff, 8'hff});
    queue_bytes('{x224_pkg::DT_LI_BYTE, x224_pkg::TPDU_DT, 8'h81, 8'h55});

    for (seg = 0; seg < 9; seg++) begin
      if (seg != 0) begin
        wait_drained();
        program_accept_mask(MASK_PLAN[seg]);
      end
      case (seg / 3)
        0: begin
          src_idle_pct = 20;
          snk_idle_pct = 86;
        end
        1: begin
          src_idle_pct = 86;
          snk_idle_pct = 20;
        end
        default: begin
          src_idle_pct = 0;
          snk_idle_pct = 0;
        end
      endcase
      seg_start = queued_count;
      while (queued_count - seg_start < SEG_BYTES)
        queue_random_frame();
    end

    wait_drained();
    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
